@@ hw/rtl/gtm_pkg.sv @@
// Shared types and constants of the Goertzel tone magnitude core.
// Used by the sample front end, the block queue, the magnitude engine and the top level.
// No dependencies.
package gtm_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int STATE_WIDTH  = 32;
  localparam int COEFF_WIDTH  = 16;
  localparam int COEFF_FRAC   = 14;
  localparam int MAG_WIDTH    = 32;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_IDX_WIDTH = 2;

  // Width of a rounded coefficient product and of the real and imaginary parts.
  localparam int PART_WIDTH  = STATE_WIDTH + COEFF_WIDTH - COEFF_FRAC + 2;
  localparam int FPROD_WIDTH = STATE_WIDTH + COEFF_WIDTH;
  localparam int MUL_WIDTH   = ((STATE_WIDTH > MAG_WIDTH) ? STATE_WIDTH : MAG_WIDTH) + 1;
  localparam int SQ_WIDTH    = 2 * MAG_WIDTH;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_FEEDBACK = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COSINE   = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SINE     = 2'd2;

  localparam logic signed [COEFF_WIDTH-1:0] FEEDBACK_RESET = '0;
  localparam logic signed [COEFF_WIDTH-1:0] COSINE_RESET   = COEFF_WIDTH'(1 << COEFF_FRAC);
  localparam logic signed [COEFF_WIDTH-1:0] SINE_RESET     = '0;

  typedef struct packed {
    logic signed [COEFF_WIDTH-1:0] feedback;
    logic signed [COEFF_WIDTH-1:0] cosine;
    logic signed [COEFF_WIDTH-1:0] sine;
  } coeff_t;

  // Final state of one analysis block, handed from the front end to the engine.
  typedef struct packed {
    logic signed [STATE_WIDTH-1:0] delay_one;
    logic signed [STATE_WIDTH-1:0] delay_two;
  } block_t;

  typedef enum logic [2:0] {
    F_EMPTY = 3'b001,
    F_MUL   = 3'b010,
    F_ADD   = 3'b100
  } front_state_e;

  typedef enum logic [8:0] {
    B_IDLE = 9'b000000001,
    B_PCOS = 9'b000000010,
    B_PSIN = 9'b000000100,
    B_ABS  = 9'b000001000,
    B_SQRE = 9'b000010000,
    B_SQIM = 9'b000100000,
    B_SUM  = 9'b001000000,
    B_ROOT = 9'b010000000,
    B_OUT  = 9'b100000000
  } back_state_e;

endpackage

@@ hw/rtl/gtm_front.sv @@
// Sample front end: accepts samples and runs the Goertzel recurrence.
// Pushes the final state of each block into the block queue. Depends on gtm_pkg.
module gtm_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  gtm_pkg::coeff_t                        coeff_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [gtm_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic                                   block_end_i,
  output logic                                   push_valid_o,
  input  logic                                   push_ready_i,
  output gtm_pkg::block_t                        push_data_o
);

  localparam int SW = gtm_pkg::STATE_WIDTH;
  localparam int PW = gtm_pkg::PART_WIDTH;
  localparam logic signed [gtm_pkg::FPROD_WIDTH-1:0] ROUND_V =
    gtm_pkg::FPROD_WIDTH'(1 << (gtm_pkg::COEFF_FRAC - 1));
  localparam logic signed [PW-1:0] SAT_HI = PW'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

  gtm_pkg::front_state_e state_q, state_d;
  logic signed [gtm_pkg::SAMPLE_WIDTH-1:0] sample_q;
  logic                                    last_q;
  logic signed [SW-1:0]                    d1_q, d1_d, d2_q, d2_d;
  logic signed [gtm_pkg::FPROD_WIDTH-1:0]  prod_q;
  logic signed [gtm_pkg::FPROD_WIDTH-1:0]  prod_rnd;
  logic signed [PW-1:0]                    sum;
  logic signed [SW-1:0]                    s0;
  logic                                    commit;
  logic                                    accept;

  assign prod_rnd = (prod_q + ROUND_V) >>> gtm_pkg::COEFF_FRAC;
  assign sum = PW'(sample_q) + $signed(prod_rnd[PW-1:0]) - PW'(d2_q);

  always_comb begin
    if (sum > SAT_HI) begin
      s0 = SAT_HI[SW-1:0];
    end else if (sum < SAT_LO) begin
      s0 = SAT_LO[SW-1:0];
    end else begin
      s0 = sum[SW-1:0];
    end
  end

  assign commit       = (state_q == gtm_pkg::F_ADD) && (!last_q || push_ready_i);
  assign in_ready_o   = (state_q == gtm_pkg::F_EMPTY) || commit;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = (state_q == gtm_pkg::F_ADD) && last_q;
  assign push_data_o  = '{delay_one: s0, delay_two: d1_q};

  always_comb begin
    state_d = state_q;
    d1_d    = d1_q;
    d2_d    = d2_q;
    case (state_q)
      gtm_pkg::F_EMPTY: begin
        if (accept) begin
          state_d = gtm_pkg::F_MUL;
        end
      end
      gtm_pkg::F_MUL: begin
        state_d = gtm_pkg::F_ADD;
      end
      gtm_pkg::F_ADD: begin
        if (commit) begin
          if (last_q) begin
            d1_d = '0;
            d2_d = '0;
          end else begin
            d1_d = s0;
            d2_d = d1_q;
          end
          state_d = accept ? gtm_pkg::F_MUL : gtm_pkg::F_EMPTY;
        end
      end
      default: begin
        state_d = gtm_pkg::F_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gtm_pkg::F_EMPTY;
      d1_q    <= '0;
      d2_q    <= '0;
    end else begin
      state_q <= state_d;
      d1_q    <= d1_d;
      d2_q    <= d2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
      last_q   <= block_end_i;
    end
    prod_q <= coeff_i.feedback * d1_q;
  end

endmodule

@@ hw/rtl/gtm_queue.sv @@
// Short queue of finished block states between the front end and the engine.
// Depends on gtm_pkg.
module gtm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  gtm_pkg::block_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output gtm_pkg::block_t pop_data_o
);

  localparam int DEPTH = gtm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gtm_pkg::block_t  entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/gtm_back.sv @@
// Magnitude engine: forms the real and imaginary parts of a finished block,
// squares them on one shared multiplier and takes a bit-serial square root. Depends on gtm_pkg.
module gtm_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gtm_pkg::coeff_t                   coeff_i,
  input  logic                              pop_valid_i,
  output logic                              pop_ready_o,
  input  gtm_pkg::block_t                   pop_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gtm_pkg::MAG_WIDTH-1:0]     magnitude_o
);

  localparam int SW  = gtm_pkg::STATE_WIDTH;
  localparam int PW  = gtm_pkg::PART_WIDTH;
  localparam int MW  = gtm_pkg::MUL_WIDTH;
  localparam int QW  = gtm_pkg::SQ_WIDTH;
  localparam int AW  = gtm_pkg::MAG_WIDTH;
  localparam int CW  = $clog2(AW);
  localparam logic signed [2*MW-1:0] ROUND_V = (2*MW)'(1 << (gtm_pkg::COEFF_FRAC - 1));
  localparam logic [QW-1:0] ROOT_BIT0 = QW'(1) << (QW - 2);

  gtm_pkg::back_state_e state_q, state_d;
  logic signed [SW-1:0]     d1_q, d2_q;
  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [2*MW-1:0]   prod, prod_q, prod_rnd;
  logic signed [PW-1:0]     part, re_q;
  logic [PW-1:0]            ar_full, ai_full;
  logic [AW-1:0]            ar_q, ai_q;
  logic                     sat_q;
  logic [QW-1:0]            sq_q, rem_q, root_q, bit_q, trial;
  logic [QW:0]              sq_sum;
  logic [CW-1:0]            step_q;
  logic                     out_valid_q;
  logic [AW-1:0]            mag_q;
  logic                     out_free;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      gtm_pkg::B_PCOS: begin
        mul_a = MW'(coeff_i.cosine);
        mul_b = MW'(d2_q);
      end
      gtm_pkg::B_PSIN: begin
        mul_a = MW'(coeff_i.sine);
        mul_b = MW'(d2_q);
      end
      gtm_pkg::B_SQRE: begin
        mul_a = MW'($signed({1'b0, ar_q}));
        mul_b = MW'($signed({1'b0, ar_q}));
      end
      gtm_pkg::B_SQIM: begin
        mul_a = MW'($signed({1'b0, ai_q}));
        mul_b = MW'($signed({1'b0, ai_q}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_rnd = (prod_q + ROUND_V) >>> gtm_pkg::COEFF_FRAC;
  assign part     = $signed(prod_rnd[PW-1:0]);
  assign ar_full  = re_q[PW-1] ? PW'(-re_q) : PW'(re_q);
  assign ai_full  = part[PW-1] ? PW'(-part) : PW'(part);
  assign sq_sum   = {1'b0, sq_q} + {1'b0, prod_q[QW-1:0]};
  assign trial    = root_q + bit_q;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_ready_o = (state_q == gtm_pkg::B_IDLE);
  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      gtm_pkg::B_IDLE: begin
        if (pop_valid_i) begin
          state_d = gtm_pkg::B_PCOS;
        end
      end
      gtm_pkg::B_PCOS: state_d = gtm_pkg::B_PSIN;
      gtm_pkg::B_PSIN: state_d = gtm_pkg::B_ABS;
      gtm_pkg::B_ABS:  state_d = gtm_pkg::B_SQRE;
      gtm_pkg::B_SQRE: state_d = gtm_pkg::B_SQIM;
      gtm_pkg::B_SQIM: state_d = gtm_pkg::B_SUM;
      gtm_pkg::B_SUM:  state_d = gtm_pkg::B_ROOT;
      gtm_pkg::B_ROOT: begin
        if (step_q == CW'(AW - 1)) begin
          state_d = gtm_pkg::B_OUT;
        end
      end
      gtm_pkg::B_OUT: begin
        if (out_free) begin
          state_d = gtm_pkg::B_IDLE;
        end
      end
      default: state_d = gtm_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gtm_pkg::B_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == gtm_pkg::B_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == gtm_pkg::B_ROOT) begin
        step_q <= step_q + CW'(1);
      end else begin
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    case (state_q)
      gtm_pkg::B_IDLE: begin
        d1_q <= pop_data_i.delay_one;
        d2_q <= pop_data_i.delay_two;
      end
      gtm_pkg::B_PSIN: begin
        re_q <= PW'(d1_q) - part;
      end
      gtm_pkg::B_ABS: begin
        ar_q  <= ar_full[AW-1:0];
        ai_q  <= ai_full[AW-1:0];
        sat_q <= (|ar_full[PW-1:AW]) || (|ai_full[PW-1:AW]);
      end
      gtm_pkg::B_SQIM: begin
        sq_q <= prod_q[QW-1:0];
      end
      gtm_pkg::B_SUM: begin
        rem_q  <= sq_sum[QW-1:0];
        sat_q  <= sat_q || sq_sum[QW];
        root_q <= '0;
        bit_q  <= ROOT_BIT0;
      end
      gtm_pkg::B_ROOT: begin
        if (rem_q >= trial) begin
          rem_q  <= rem_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      gtm_pkg::B_OUT: begin
        if (out_free) begin
          mag_q <= sat_q ? {AW{1'b1}} : root_q[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/goertzel_tone_magnitude_core.sv @@
// Top level of the Goertzel single-bin tone magnitude core.
// Holds the coefficient registers and connects gtm_front, gtm_queue and gtm_back; uses gtm_pkg.
//
// A sample passes through F_MUL for the feedback product and F_ADD for the saturating add, and
// the next sample is taken as it commits in F_ADD, or while the front end is empty. Each
// block's final state goes through a two-entry queue to the magnitude engine, which forms two
// coefficient products and two squares on its one shared multiplier, then thirty-two steps of
// the bit-serial square root. The front end stalls only when a block ends while the queue is
// full. The user must write coefficients only while no transaction is in flight (unenforced).
module goertzel_tone_magnitude_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [gtm_pkg::CFG_IDX_WIDTH-1:0]       cfg_index_i,
  input  logic [gtm_pkg::COEFF_WIDTH-1:0]         cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [gtm_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic                                    block_end_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [gtm_pkg::MAG_WIDTH-1:0]           magnitude_o
);

  gtm_pkg::coeff_t coeff_q;
  gtm_pkg::block_t push_data, pop_data;
  logic            push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q.feedback <= gtm_pkg::FEEDBACK_RESET;
      coeff_q.cosine   <= gtm_pkg::COSINE_RESET;
      coeff_q.sine     <= gtm_pkg::SINE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gtm_pkg::REG_FEEDBACK: coeff_q.feedback <= $signed(cfg_data_i);
        gtm_pkg::REG_COSINE:   coeff_q.cosine   <= $signed(cfg_data_i);
        gtm_pkg::REG_SINE:     coeff_q.sine     <= $signed(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  gtm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coeff_i      (coeff_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .block_end_i  (block_end_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  gtm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  gtm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coeff_i     (coeff_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .magnitude_o (magnitude_o)
  );

endmodule

@@ tb/goertzel_tone_magnitude_checker.sv @@
// Checker for the Goertzel tone magnitude core: watches the coefficient, sample and result channels.
// Predicts each block's magnitude from its own copy of the coefficients and delay words.
// Depends on gtm_pkg for widths and register indexes.
`timescale 1ns / 100ps

module goertzel_tone_magnitude_checker
  import gtm_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [CFG_IDX_WIDTH-1:0]       cfg_index_i,
  input  logic [COEFF_WIDTH-1:0]         cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           block_end_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [MAG_WIDTH-1:0]           magnitude_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  logic signed [COEFF_WIDTH-1:0] feedback_q;
  logic signed [COEFF_WIDTH-1:0] cosine_q;
  logic signed [COEFF_WIDTH-1:0] sine_q;
  logic signed [STATE_WIDTH-1:0] delay_one_q;
  logic signed [STATE_WIDTH-1:0] delay_two_q;
  logic [MAG_WIDTH-1:0]          magnitude_queue[$];
  logic [MAG_WIDTH-1:0]          oldest_magnitude;
  longint                        recurrence_sum;
  longint                        part_real;
  longint                        part_imag;

  function automatic longint coeff_product(input longint coeff, input longint value);
    return (coeff * value + (longint'(1) << (COEFF_FRAC - 1))) >>> COEFF_FRAC;
  endfunction

  function automatic logic [STATE_WIDTH-1:0] clamp_state(input longint value);
    longint upper;
    longint lower;
    upper = (longint'(1) << (STATE_WIDTH - 1)) - 1;
    lower = -upper - 1;
    if (value > upper) begin
      return STATE_WIDTH'(upper);
    end
    if (value < lower) begin
      return STATE_WIDTH'(lower);
    end
    return STATE_WIDTH'(value);
  endfunction

  function automatic logic [MAG_WIDTH-1:0] tone_magnitude(input longint re, input longint im);
    longint unsigned abs_re;
    longint unsigned abs_im;
    longint unsigned root;
    longint unsigned trial;
    logic [64:0]     power;
    abs_re = (re < 0) ? longint'(-re) : re;
    abs_im = (im < 0) ? longint'(-im) : im;
    if (abs_re > 64'hFFFF_FFFF || abs_im > 64'hFFFF_FFFF) begin
      return '1;
    end
    power = 65'(abs_re * abs_re) + 65'(abs_im * abs_im);
    if (power[64]) begin
      return '1;
    end
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (65'(trial * trial) <= power) begin
        root = trial;
      end
    end
    return MAG_WIDTH'(root);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ERROR %s", $time, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feedback_q  = FEEDBACK_RESET;
      cosine_q    = COSINE_RESET;
      sine_q      = SINE_RESET;
      delay_one_q = '0;
      delay_two_q = '0;
      magnitude_queue.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (magnitude_queue.size() == 0) begin
          report_mismatch($sformatf("magnitude %0d arrived with no block pending", magnitude_i));
        end else begin
          oldest_magnitude = magnitude_queue.pop_front();
          if (magnitude_i !== oldest_magnitude) begin
            report_mismatch($sformatf("magnitude %0d, predicted %0d",
                                      magnitude_i, oldest_magnitude));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FEEDBACK: begin
            feedback_q = cfg_data_i;
          end
          REG_COSINE: begin
            cosine_q = cfg_data_i;
          end
          REG_SINE: begin
            sine_q = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        recurrence_sum = longint'(sample_i) + coeff_product(feedback_q, delay_one_q)
                         - longint'(delay_two_q);
        delay_two_q = delay_one_q;
        delay_one_q = clamp_state(recurrence_sum);
        if (block_end_i) begin
          part_real = longint'(delay_one_q) - coeff_product(cosine_q, delay_two_q);
          part_imag = coeff_product(sine_q, delay_two_q);
          magnitude_queue.push_back(tone_magnitude(part_real, part_imag));
          delay_one_q = '0;
          delay_two_q = '0;
        end
      end
      pending_o = magnitude_queue.size();
    end
  end

endmodule

@@ tb/goertzel_tone_magnitude_core_tb.sv @@
// Top of the Goertzel tone magnitude testbench: clock, reset, coefficient writes and sample stimulus.
// Instantiates goertzel_tone_magnitude_core and goertzel_tone_magnitude_checker; uses gtm_pkg.
`timescale 1ns / 100ps

module goertzel_tone_magnitude_core_tb;
  import gtm_pkg::*;

  localparam logic [CFG_IDX_WIDTH-1:0] UNMAPPED_REG = 2'd3;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES    = 64;
  localparam int PHASE_ITEMS     = 8;
  localparam int RESONANT_ITEMS  = 368;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0]       cfg_index_i;
  logic [COEFF_WIDTH-1:0]         cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic signed [SAMPLE_WIDTH-1:0] sample_i;
  logic                           block_end_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [MAG_WIDTH-1:0]           magnitude_o;

  int   mismatch_total;
  int   blocks_pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_off_request;
  int   phase_items;
  int   block_len;

  goertzel_tone_magnitude_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .block_end_i (block_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .magnitude_o (magnitude_o)
  );

  goertzel_tone_magnitude_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .sample_i     (sample_i),
    .block_end_i  (block_end_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .magnitude_i  (magnitude_o),
    .fail_count_o (mismatch_total),
    .pending_o    (blocks_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 400000);
    $display("Verification failed");
    $finish;
  end

  // The long hold-off lets the engine and its queue fill so that the sample channel stalls.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(3))
      0: begin
        return $urandom_range(1) ? 16'sd32767 : -16'sd32768;
      end
      1: begin
        return SAMPLE_WIDTH'($urandom_range(127)) - SAMPLE_WIDTH'(64);
      end
      default: begin
        return SAMPLE_WIDTH'($urandom);
      end
    endcase
  endfunction

  task automatic program_coeffs(input logic [COEFF_WIDTH-1:0] feedback,
                                input logic [COEFF_WIDTH-1:0] cosine,
                                input logic [COEFF_WIDTH-1:0] sine);
    logic [CFG_IDX_WIDTH-1:0] index_list[4];
    logic [COEFF_WIDTH-1:0]   data_list[4];
    index_list = '{REG_FEEDBACK, REG_COSINE, REG_SINE, UNMAPPED_REG};
    data_list  = '{feedback, cosine, sine, COEFF_WIDTH'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= index_list[k];
      cfg_data_i  <= data_list[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_i    <= value;
    block_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    wait (blocks_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni           = 1'b0;
    hold_off_request = 1'b0;
    send_idle_pct    = 31;
    recv_idle_pct    = 59;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= REG_FEEDBACK;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    sample_i         <= '0;
    block_end_i      <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients: single-sample blocks at the sample extremes and at zero, then a short block.
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
    drain_and_settle();

    program_coeffs(-16'sd32768, 16'sd32767, -16'sd32768);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b0);
    drain_and_settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        program_coeffs(16'sd32767, -16'sd32768, 16'sd32767);
      end else if (phase == 1) begin
        program_coeffs(-16'sd32768, 16'sd32767, -16'sd32768);
      end else begin
        program_coeffs(COEFF_WIDTH'($urandom), COEFF_WIDTH'($urandom), COEFF_WIDTH'($urandom));
      end
      if (phase == 4) begin
        hold_off_request = 1'b1;
      end

      // A block resonant at half the sample rate, long enough to drive the delay words into
      // saturation.
      if (phase == 1) begin
        for (int k = 0; k < RESONANT_ITEMS; k++) begin
          send_sample((k % 2) ? -16'sd32768 : 16'sd32767, k == RESONANT_ITEMS - 1);
        end
      end

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        block_len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        if (phase == 4) begin
          block_len = 1;
        end
        for (int k = 0; k < block_len; k++) begin
          send_sample(pick_sample(), k == block_len - 1);
        end
        phase_items += block_len;
      end
      for (int k = 0; k < 3; k++) begin
        send_sample(SAMPLE_WIDTH'($urandom), $urandom_range(3) == 0);
      end
      drain_and_settle();
    end

    if (mismatch_total == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/gtm_pkg.sv
hw/rtl/gtm_front.sv
hw/rtl/gtm_queue.sv
hw/rtl/gtm_back.sv
hw/rtl/goertzel_tone_magnitude_core.sv
tb/goertzel_tone_magnitude_checker.sv
tb/goertzel_tone_magnitude_core_tb.sv
